@@ rtl/crba_pkg.sv @@
package crba_pkg;

  localparam int MaxBlocks = 1024;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = IdxW + 1;

  typedef enum logic [1:0] {
    CMD_RESERVE  = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_VALIDATE = 2'd2,
    CMD_COUNT    = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_CLEAR = 8'b00000010,
    ST_SCAN  = 8'b00000100,
    ST_MARK  = 8'b00001000,
    ST_RUN   = 8'b00010000,
    ST_COUNT = 8'b00100000,
    ST_RD    = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

endpackage

@@ rtl/crba_ram.sv @@
module crba_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/contiguous_run_bitmap_allocator_top.sv @@
// next-fit allocator: one command per start beat, busy from accept until the result strobe
// count reads each block below blocks_in_use; release/validate read the run block by
//   block; reserve scans from the next-fit pointer (at most blocks_in_use + run_length
//   blocks), marks run_length blocks; refused reserve or block-zero release reads nothing
// throughput: next command accepted in the cycle done is high; receiver cannot stall
// reset and every blocks_in_use write clear all MaxBlocks map entries, busy high
module contiguous_run_bitmap_allocator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [10:0]           run_length,
  input  logic [9:0]            block_index,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_data,
  output logic                  done,
  output logic [10:0]           answer,
  output logic                  success
);
  import crba_pkg::*;

  state_t          state;
  cmd_t            op;
  logic [CntW-1:0] size;      // blocks in use
  logic [CntW-1:0] ptr;       // next-fit pointer
  logic [CntW-1:0] want;
  logic [CntW-1:0] pos;       // block being visited
  logic [CntW-1:0] cand;      // candidate run start
  logic [CntW-1:0] span;      // free blocks found from cand
  logic [CntW-1:0] steps;     // blocks scanned so far
  logic [CntW-1:0] acc;
  logic            first;
  logic            rel;

  // map memory: bit 1 used, bit 0 continuation
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [1:0]      wdata, rdata;

  crba_ram #(.Width(2), .Depth(MaxBlocks)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CntW-1:0] pos_inc, cfg_size;
  logic            pos_in;
  assign pos_inc = pos + 1'b1;
  assign pos_in  = pos < size;
  assign cfg_size = (cfg_data == '0) ? CntW'(1) :
                    (cfg_data > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : cfg_data;

  always_comb begin
    raddr = pos[IdxW-1:0];
    we    = 1'b0;
    waddr = pos[IdxW-1:0];
    wdata = 2'b00;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = (pos == '0) ? 2'b10 : 2'b00;
      end
      ST_MARK: begin
        we    = 1'b1;
        wdata = (pos == cand) ? 2'b10 : 2'b11;
      end
      ST_RUN: begin
        // clear the block just read when releasing and it belongs to the run
        we    = rel && pos_in && rdata[1] && (first ? !rdata[0] : rdata[0]);
        wdata = 2'b00;
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pos   <= '0;
      size  <= CntW'(MaxBlocks);
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        size  <= cfg_size;
        ptr   <= '0;
        pos   <= '0;
        state <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (start) begin
              op    <= cmd_t'(cmd);
              want  <= run_length;
              acc   <= '0;
              first <= 1'b1;
              rel   <= cmd_t'(cmd) == CMD_RELEASE;
              unique case (cmd_t'(cmd))
                CMD_RESERVE: begin
                  if (run_length == '0 || run_length > size) begin
                    state <= ST_DONE;
                  end else begin
                    pos   <= (ptr >= size) ? '0 : ptr;
                    cand  <= (ptr >= size) ? '0 : ptr;
                    span  <= '0;
                    steps <= '0;
                    state <= ST_RD;
                  end
                end
                CMD_RELEASE, CMD_VALIDATE: begin
                  pos   <= {1'b0, block_index};
                  state <= (cmd_t'(cmd) == CMD_RELEASE && block_index == '0) ?
                           ST_DONE : ST_RD;
                end
                CMD_COUNT: begin
                  pos   <= '0;
                  state <= ST_RD;
                end
              endcase
            end
          end
          ST_CLEAR: begin
            pos <= pos_inc;
            if (pos == CntW'(MaxBlocks - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_RD: begin
            // read address presented, data valid next cycle
            unique case (op)
              CMD_RESERVE: state <= ST_SCAN;
              CMD_COUNT:   state <= ST_COUNT;
              default:     state <= ST_RUN;
            endcase
          end
          ST_SCAN: begin
            if (rdata[1]) begin
              // used block: restart candidate after it, wrap to 0
              steps <= steps + span + 1'b1;
              span  <= '0;
              if (pos_inc >= size) begin
                pos <= '0; cand <= '0;
              end else begin
                pos <= pos_inc; cand <= pos_inc;
              end
              state <= (steps + span + 1'b1 >= size) ? ST_DONE : ST_RD;
            end else if (span + 1'b1 == want) begin
              pos   <= cand;
              acc   <= cand;
              state <= ST_MARK;
            end else if (pos_inc >= size) begin
              // run would cross the end
              steps <= steps + span + 1'b1;
              span  <= '0;
              pos   <= '0;
              cand  <= '0;
              state <= (steps + span + 1'b1 >= size) ? ST_DONE : ST_RD;
            end else begin
              span  <= span + 1'b1;
              pos   <= pos_inc;
              state <= ST_RD;
            end
          end
          ST_MARK: begin
            pos <= pos_inc;
            if (pos_inc == cand + want) begin
              ptr   <= pos_inc;
              state <= ST_DONE;
            end
          end
          ST_RUN: begin
            first <= 1'b0;
            if (pos_in && rdata[1] && (first ? !rdata[0] : rdata[0])) begin
              acc   <= acc + 1'b1;
              pos   <= pos_inc;
              state <= ST_RD;
            end else begin
              state <= ST_DONE;
            end
          end
          ST_COUNT: begin
            if (rdata[1]) begin
              acc <= acc + 1'b1;
            end
            pos   <= pos_inc;
            state <= (pos_inc >= size) ? ST_DONE : ST_RD;
          end
          ST_DONE: begin
            done    <= 1'b1;
            answer  <= acc;
            success <= acc != '0;
            state   <= ST_IDLE;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end
endmodule

@@ tb/tb_contiguous_run_bitmap_allocator_top.sv @@
`timescale 1ns / 100ps

import crba_pkg::*;

typedef struct packed {
  logic [10:0] answer;
  logic        success;
} alloc_reply_t;

class alloc_scoreboard;
  bit              used_bit [MaxBlocks];
  bit              cont_bit [MaxBlocks];
  int unsigned     next_fit;
  int unsigned     span_limit;
  alloc_reply_t    replies_due [$];
  int              errors;

  function new();
    set_blocks(MaxBlocks);
  endfunction

  // register write also clears maps and pointer
  function void set_blocks(int unsigned value);
    int unsigned v;
    v = value & 11'h7ff;
    if (v == 0) v = 1;
    if (v > MaxBlocks) v = MaxBlocks;
    span_limit = v;
    foreach (used_bit[i]) begin
      used_bit[i] = 0;
      cont_bit[i] = 0;
    end
    used_bit[0] = 1;
    next_fit = 0;
  endfunction

  function int unsigned reserve_run(int unsigned n);
    int unsigned free_to_end [MaxBlocks + 1];
    int unsigned first;
    int unsigned pos;
    if (n == 0 || n > span_limit) return 0;
    free_to_end[span_limit] = 0;
    for (int i = span_limit; i > 0; i--)
      free_to_end[i - 1] = used_bit[i - 1] ? 0 : free_to_end[i] + 1;
    first = next_fit % span_limit;
    for (int j = 0; j < span_limit; j++) begin
      pos = first + j;
      if (pos >= span_limit) pos -= span_limit;
      if (free_to_end[pos] >= n) begin
        for (int k = 0; k < n; k++) begin
          used_bit[pos + k] = 1;
          cont_bit[pos + k] = 1;
        end
        cont_bit[pos] = 0;
        next_fit = pos + n;
        return pos;
      end
    end
    return 0;
  endfunction

  function int unsigned walk_run(int unsigned pos, bit clear_it);
    int unsigned len;
    len = 0;
    if (pos >= span_limit || !used_bit[pos] || cont_bit[pos]) return 0;
    do begin
      if (clear_it) begin
        used_bit[pos] = 0;
        cont_bit[pos] = 0;
      end
      len++;
      pos++;
    end while (pos < span_limit && cont_bit[pos]);
    return len;
  endfunction

  // accepted command: work out and queue its reply, hand the answer back
  function int unsigned note_command(cmd_t op, logic [10:0] len, logic [9:0] idx);
    int unsigned ans;
    alloc_reply_t r;
    ans = 0;
    case (op)
      CMD_RESERVE:  ans = reserve_run(len);
      CMD_RELEASE:  ans = (idx == 0) ? 0 : walk_run(idx, 1);
      CMD_VALIDATE: ans = walk_run(idx, 0);
      default: begin
        for (int i = 0; i < span_limit; i++) ans += used_bit[i];
      end
    endcase
    r.answer  = ans[10:0];
    r.success = (ans[10:0] != 0);
    replies_due.push_back(r);
    return ans;
  endfunction

  function void check_reply(logic [10:0] answer, logic success);
    alloc_reply_t want;
    if (replies_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected reply: answer %0d success %0b", answer, success);
      return;
    end
    want = replies_due.pop_front();
    if (answer !== want.answer || success !== want.success) begin
      errors++;
      if (errors <= 10)
        $display("reply mismatch: expected answer %0d success %0b, got answer %0d success %0b",
                 want.answer, want.success, answer, success);
    end
  endfunction
endclass

module tb_contiguous_run_bitmap_allocator_top;

  localparam longint CycleLimit = 30_000_000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [10:0] run_length;
  logic [9:0]  block_index;
  logic        cfg_we;
  logic [10:0] cfg_data;
  logic        done;
  logic [10:0] answer;
  logic        success;

  alloc_scoreboard alloc_sb;
  longint          cycle_count;
  bit              calm;        // no sender gaps while set
  int unsigned     live_starts [$];

  contiguous_run_bitmap_allocator_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .run_length (run_length),
    .block_index(block_index),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .answer     (answer),
    .success    (success)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // every done strobe is one reply beat, checked in order
  always @(posedge clk) begin
    if (!rst && done) alloc_sb.check_reply(answer, success);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_contiguous_run_bitmap_allocator_top: FAIL");
      $finish;
    end
  end

  // issue one command; called just after a falling edge, returns at a falling edge once the block has taken it
  task automatic send_cmd(cmd_t op, logic [10:0] len, logic [9:0] idx);
    int unsigned ans;
    if (!calm && $urandom_range(99) < 22) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start       = 1;
    cmd         = op;
    run_length  = len;
    block_index = idx;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    ans = alloc_sb.note_command(op, len, idx);
    // track live run starts so releases mostly hit real runs
    if (op == CMD_RESERVE && ans != 0) live_starts.push_back(ans);
    if (op == CMD_RELEASE) begin
      foreach (live_starts[i])
        if (live_starts[i] == idx) begin
          live_starts.delete(i);
          break;
        end
    end
    @(negedge clk);
    start = 0;
  endtask

  // wait until all replies are in and the block is idle
  task automatic drain();
    while (alloc_sb.replies_due.size() != 0 || busy) @(negedge clk);
  endtask

  // register write, only while idle; clearing pass follows inside the block
  task automatic write_blocks(logic [10:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_we   = 1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 0;
    cfg_data = ~value;
    alloc_sb.set_blocks(value);
    live_starts.delete();
  endtask

  // random mix: mostly reserves and releases of real runs, some noise
  task automatic random_phase(int count);
    int unsigned roll;
    int unsigned lim;
    logic [10:0] len;
    logic [9:0]  idx;
    lim = alloc_sb.span_limit;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      roll = $urandom_range(99);
      len  = 11'($urandom_range(1, (lim / 4) + 1));
      if ($urandom_range(19) == 0) len = 11'($urandom_range(0, 2047));
      if ($urandom_range(29) == 0) len = 0;
      idx = 10'($urandom_range(0, 1023));
      if (live_starts.size() != 0 && $urandom_range(9) < 7)
        idx = 10'(live_starts[$urandom_range(0, live_starts.size() - 1)]);
      else if ($urandom_range(3) == 0 && lim > 1)
        idx = 10'($urandom_range(0, lim - 1));
      if (roll < 40)      send_cmd(CMD_RESERVE, len, idx);
      else if (roll < 72) send_cmd(CMD_RELEASE, len, idx);
      else if (roll < 88) send_cmd(CMD_VALIDATE, len, idx);
      else                send_cmd(CMD_COUNT, len, idx);
    end
    calm = 0;
  endtask

  initial begin
    bit passed;
    alloc_sb    = new();
    cycle_count = 0;
    calm        = 0;
    rst         = 1;
    start       = 0;
    cmd         = CMD_COUNT;
    run_length  = 0;
    block_index = 0;
    cfg_we      = 0;
    cfg_data    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: full size after reset
    send_cmd(CMD_COUNT, 0, 0);
    send_cmd(CMD_RESERVE, 0, 0);            // zero length
    send_cmd(CMD_RESERVE, 11'd1024, 0);     // longer than any free span
    send_cmd(CMD_RESERVE, 11'h7ff, 10'h3ff);
    send_cmd(CMD_VALIDATE, 0, 0);           // block zero is a run of one
    send_cmd(CMD_RELEASE, 0, 0);            // release of block zero refused
    send_cmd(CMD_RESERVE, 11'd3, 0);
    send_cmd(CMD_VALIDATE, 0, 10'd1);
    send_cmd(CMD_VALIDATE, 0, 10'd2);       // inside a run
    send_cmd(CMD_RELEASE, 0, 10'd3);        // inside a run
    send_cmd(CMD_RESERVE, 11'd1020, 0);     // fills the rest exactly
    send_cmd(CMD_COUNT, 0, 0);
    send_cmd(CMD_RELEASE, 0, 10'd1);
    send_cmd(CMD_RESERVE, 11'd3, 0);        // pointer at the end wraps
    send_cmd(CMD_RELEASE, 0, 10'd4);

    // directed: small size, indices beyond the end
    write_blocks(11'd16);
    send_cmd(CMD_RESERVE, 11'd15, 0);
    send_cmd(CMD_VALIDATE, 0, 10'd20);
    send_cmd(CMD_RELEASE, 0, 10'h3ff);
    send_cmd(CMD_RELEASE, 0, 10'd1);
    send_cmd(CMD_RESERVE, 11'd16, 0);
    send_cmd(CMD_COUNT, 0, 0);

    write_blocks(11'd0);                    // zero reads as one block
    send_cmd(CMD_RESERVE, 11'd1, 0);
    send_cmd(CMD_COUNT, 0, 0);
    random_phase(20);

    write_blocks(11'd64);
    random_phase(400);
    write_blocks(11'h7ff);                  // saturates to the maximum
    random_phase(150);
    write_blocks(11'd2);
    random_phase(60);
    write_blocks(11'd200);
    random_phase(300);
    write_blocks(11'd17);
    random_phase(250);
    write_blocks(11'd1024);
    random_phase(150);

    drain();
    repeat (3000) @(posedge clk);
    passed = (alloc_sb.errors == 0) && (alloc_sb.replies_due.size() == 0);
    if (passed) begin
      $display("tb_contiguous_run_bitmap_allocator_top: PASS");
    end else begin
      $display("tb_contiguous_run_bitmap_allocator_top: FAIL");
    end
    $finish;
  end

endmodule
